@@ hdl/tml_pkg.sv @@
// Shared definitions for the triangle metrics pipeline.
// Holds parameter defaults, result field widths and the result record type.
// No dependencies.
package tml_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // Pipeline registers in the geometry front end (differences through Heron term).
    localparam int GEOM_STAGES = 6;

    localparam int AREA_W  = 32;
    localparam int PERIM_W = 23;

    typedef struct packed {
        logic               is_triangle;
        logic [AREA_W-1:0]  area_fixed;
        logic [PERIM_W-1:0] perimeter_fixed;
        logic               is_equilateral;
    } tml_result_t;

endpackage

@@ hdl/tml_geom.sv @@
// Geometry front end: segment deltas, squared lengths, slope test and the Heron term.
// Six register stages, all advancing on one enable. Uses tml_pkg.
module tml_geom #(
    parameter int COORD_BITS = tml_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en_i,
    input  logic signed [COORD_BITS-1:0]  sx_i [3],
    input  logic signed [COORD_BITS-1:0]  sy_i [3],
    input  logic signed [COORD_BITS-1:0]  ex_i [3],
    input  logic signed [COORD_BITS-1:0]  ey_i [3],
    output logic [2*COORD_BITS:0]         sq_o [3],
    output logic [4*COORD_BITS+4:0]       q_o,
    output logic                          tri_o,
    output logic                          equi_o
);
    import tml_pkg::*;

    localparam int DX_W = COORD_BITS + 1;
    localparam int M_W  = 2 * DX_W;
    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int PR_W = 2 * SQ_W;
    localparam int Q_W  = 2 * SQ_W + 3;

    // stage 1
    logic signed [DX_W-1:0] dx_reg [3];
    logic signed [DX_W-1:0] dy_reg [3];
    // stage 2
    logic signed [M_W-1:0]  dxx_reg [3];
    logic signed [M_W-1:0]  dyy_reg [3];
    logic signed [M_W-1:0]  crs_a_reg [3];
    logic signed [M_W-1:0]  crs_b_reg [3];
    logic [2:0]             vert_reg;
    // stage 3
    logic [SQ_W-1:0]        sq3_reg [3];
    logic                   tri3_reg;
    // stage 4
    logic [PR_W-1:0]        prod_reg [6];
    logic [SQ_W-1:0]        sq4_reg [3];
    logic                   tri4_reg;
    logic                   equi4_reg;
    // stage 5
    logic [Q_W-1:0]         pos_reg;
    logic [Q_W-1:0]         neg_reg;
    logic [SQ_W-1:0]        sq5_reg [3];
    logic                   tri5_reg;
    logic                   equi5_reg;
    // stage 6
    logic [Q_W-1:0]         q_reg;
    logic [SQ_W-1:0]        sq6_reg [3];
    logic                   tri6_reg;
    logic                   equi6_reg;

    logic [2:0]             same;
    logic [Q_W-2:0]         pos_half;

    // Pairs: (0,1), (0,2), (1,2). A pair shares a slope when both are vertical
    // or, with neither vertical, the cross products match.
    always_comb begin
        same[0] = (vert_reg[0] || vert_reg[1]) ? (vert_reg[0] && vert_reg[1])
                                               : (crs_a_reg[0] == crs_b_reg[0]);
        same[1] = (vert_reg[0] || vert_reg[2]) ? (vert_reg[0] && vert_reg[2])
                                               : (crs_a_reg[1] == crs_b_reg[1]);
        same[2] = (vert_reg[1] || vert_reg[2]) ? (vert_reg[1] && vert_reg[2])
                                               : (crs_a_reg[2] == crs_b_reg[2]);
    end

    assign pos_half = (Q_W-1)'(prod_reg[0]) + (Q_W-1)'(prod_reg[1]) + (Q_W-1)'(prod_reg[2]);

    always_ff @(posedge aclk) begin
        if (en_i) begin
            for (int i = 0; i < 3; i++) begin
                dx_reg[i] <= DX_W'(ex_i[i]) - DX_W'(sx_i[i]);
                dy_reg[i] <= DX_W'(ey_i[i]) - DX_W'(sy_i[i]);

                dxx_reg[i]  <= dx_reg[i] * dx_reg[i];
                dyy_reg[i]  <= dy_reg[i] * dy_reg[i];
                vert_reg[i] <= (dx_reg[i] == '0);

                sq3_reg[i] <= SQ_W'(dxx_reg[i][SQ_W-2:0]) + SQ_W'(dyy_reg[i][SQ_W-2:0]);
                sq4_reg[i] <= sq3_reg[i];
                sq5_reg[i] <= sq4_reg[i];
                sq6_reg[i] <= sq5_reg[i];
            end
            crs_a_reg[0] <= dy_reg[0] * dx_reg[1];
            crs_b_reg[0] <= dy_reg[1] * dx_reg[0];
            crs_a_reg[1] <= dy_reg[0] * dx_reg[2];
            crs_b_reg[1] <= dy_reg[2] * dx_reg[0];
            crs_a_reg[2] <= dy_reg[1] * dx_reg[2];
            crs_b_reg[2] <= dy_reg[2] * dx_reg[1];

            tri3_reg <= !(same[0] && same[1] && same[2]);

            prod_reg[0] <= sq3_reg[0] * sq3_reg[1];
            prod_reg[1] <= sq3_reg[1] * sq3_reg[2];
            prod_reg[2] <= sq3_reg[2] * sq3_reg[0];
            prod_reg[3] <= sq3_reg[0] * sq3_reg[0];
            prod_reg[4] <= sq3_reg[1] * sq3_reg[1];
            prod_reg[5] <= sq3_reg[2] * sq3_reg[2];
            tri4_reg    <= tri3_reg;
            equi4_reg   <= (sq3_reg[0] == sq3_reg[1]) && (sq3_reg[0] == sq3_reg[2]);

            pos_reg   <= {pos_half, 1'b0};
            neg_reg   <= Q_W'(prod_reg[3]) + Q_W'(prod_reg[4]) + Q_W'(prod_reg[5]);
            tri5_reg  <= tri4_reg;
            equi5_reg <= equi4_reg;

            // clamp: impossible side lengths give zero area
            q_reg     <= (pos_reg >= neg_reg) ? (pos_reg - neg_reg) : '0;
            tri6_reg  <= tri5_reg;
            equi6_reg <= equi5_reg;
        end
    end

    assign sq_o   = sq6_reg;
    assign q_o    = q_reg;
    assign tri_o  = tri6_reg;
    assign equi_o = equi6_reg;

endmodule

@@ hdl/tml_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
// Radicand of RAD_W bits, floor root of (RAD_W+1)/2 bits. Uses tml_pkg.
module tml_isqrt #(
    parameter int RAD_W = 69
) (
    input  logic                   aclk,
    input  logic                   en_i,
    input  logic [RAD_W-1:0]       rad_i,
    output logic [(RAD_W+1)/2-1:0] root_o
);
    import tml_pkg::*;

    localparam int RT    = (RAD_W + 1) / 2;
    localparam int PW    = 2 * RT;
    localparam int REM_W = RT + 2;

    logic [REM_W-1:0] rem_reg  [RT];
    logic [RT-1:0]    root_reg [RT];
    logic [PW-1:0]    rad_reg  [RT];

    logic [REM_W-1:0] rem_p  [RT];
    logic [RT-1:0]    root_p [RT];
    logic [PW-1:0]    rad_p  [RT];
    logic [REM_W-1:0] cur    [RT];
    logic [REM_W-1:0] trial  [RT];
    logic [RT-1:0]    ge;

    always_comb begin
        for (int j = 0; j < RT; j++) begin
            if (j == 0) begin
                rem_p[j]  = '0;
                root_p[j] = '0;
                rad_p[j]  = PW'(rad_i);
            end else begin
                rem_p[j]  = rem_reg[j-1];
                root_p[j] = root_reg[j-1];
                rad_p[j]  = rad_reg[j-1];
            end
            // bring down the next two radicand bits, try root*4+1
            cur[j]   = {rem_p[j][REM_W-3:0], rad_p[j][PW-1 -: 2]};
            trial[j] = {root_p[j], 2'b01};
            ge[j]    = (cur[j] >= trial[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            for (int j = 0; j < RT; j++) begin
                rem_reg[j]  <= ge[j] ? (cur[j] - trial[j]) : cur[j];
                root_reg[j] <= {root_p[j][RT-2:0], ge[j]};
                rad_reg[j]  <= rad_p[j] << 2;
            end
        end
    end

    assign root_o = root_reg[RT-1];

endmodule

@@ hdl/tml_obuf.sv @@
// Two-entry output buffer between the pipeline and the result channel.
// Full only when both entries hold results. Uses tml_pkg.
module tml_obuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_i,
    input  tml_pkg::tml_result_t push_data_i,
    output logic                 full_o,
    output logic                 m_valid_o,
    input  logic                 m_ready_i,
    output tml_pkg::tml_result_t m_data_o
);
    import tml_pkg::*;

    tml_result_t ent_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        rd_ptr_reg, wr_ptr_reg;
    logic        pop;

    assign pop       = m_valid_o && m_ready_i;
    assign m_valid_o = (count_reg != 2'd0);
    assign full_o    = (count_reg == 2'd2);
    assign m_data_o  = ent_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push_i) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            ent_reg[wr_ptr_reg] <= push_data_i;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o) else $error("push into full output buffer");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("output buffer count out of range");
    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push_i) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("output buffer count did not drop on pop");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("output buffer pointers disagree with count");
`endif

endmodule

@@ hdl/triangle_metrics_from_lines_unit.sv @@
// Top level of the triangle metrics pipeline.
// Instantiates tml_geom, four tml_isqrt units and tml_obuf; uses tml_pkg.
//
// One transfer on the s_ channel carries three segments; exactly one result
// transfer on the m_ channel follows for each, in order. The datapath is a
// single-enable pipeline: six geometry stages (deltas, squares and slope cross
// products, squared lengths, Heron products, sums, clamp) followed by a
// square-root pipeline that resolves one root bit per stage, (AR_W+1)/2 stages
// with AR_W = 4*COORD_BITS + 5 + 2*FRAC_BITS (35 at the defaults). A new item
// is taken every cycle; the pipeline halts only while its two-entry output
// buffer holds two untaken results, and it keeps accepting while just one
// waits. Lengths, perimeter and area carry FRAC_BITS fraction bits, truncated;
// area is 0 where the side lengths break the triangle inequality.
module triangle_metrics_from_lines_unit #(
    parameter int COORD_BITS = tml_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tml_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_first_start_x,
    input  logic signed [COORD_BITS-1:0] s_first_start_y,
    input  logic signed [COORD_BITS-1:0] s_first_end_x,
    input  logic signed [COORD_BITS-1:0] s_first_end_y,
    input  logic signed [COORD_BITS-1:0] s_second_start_x,
    input  logic signed [COORD_BITS-1:0] s_second_start_y,
    input  logic signed [COORD_BITS-1:0] s_second_end_x,
    input  logic signed [COORD_BITS-1:0] s_second_end_y,
    input  logic signed [COORD_BITS-1:0] s_third_start_x,
    input  logic signed [COORD_BITS-1:0] s_third_start_y,
    input  logic signed [COORD_BITS-1:0] s_third_end_x,
    input  logic signed [COORD_BITS-1:0] s_third_end_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_triangle,
    output logic [tml_pkg::AREA_W-1:0]   m_area_fixed,
    output logic [tml_pkg::PERIM_W-1:0]  m_perimeter_fixed,
    output logic                         m_is_equilateral
);
    import tml_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int Q_W   = 2 * SQ_W + 3;
    localparam int AR_W  = Q_W + 2 * FRAC_BITS;
    localparam int RT    = (AR_W + 1) / 2;
    localparam int DEPTH = GEOM_STAGES + RT;

    logic signed [COORD_BITS-1:0] sx [3];
    logic signed [COORD_BITS-1:0] sy [3];
    logic signed [COORD_BITS-1:0] ex [3];
    logic signed [COORD_BITS-1:0] ey [3];

    logic             en;
    logic             full;
    logic [DEPTH-1:0] vld_reg;
    logic [RT-1:0]    tri_dly_reg;
    logic [RT-1:0]    equi_dly_reg;

    logic [SQ_W-1:0]  sq [3];
    logic [Q_W-1:0]   q;
    logic             tri_g;
    logic             equi_g;

    logic [AR_W-1:0]  rad [4];
    logic [RT-1:0]    root [4];
    logic [RT+1:0]    len_sum;

    tml_result_t      res;
    tml_result_t      m_data;

    assign sx = '{s_first_start_x, s_second_start_x, s_third_start_x};
    assign sy = '{s_first_start_y, s_second_start_y, s_third_start_y};
    assign ex = '{s_first_end_x,   s_second_end_x,   s_third_end_x};
    assign ey = '{s_first_end_y,   s_second_end_y,   s_third_end_y};

    // The whole pipeline advances together; hold it only when the output
    // buffer cannot take another transfer.
    assign en      = !full;
    assign s_ready = en;

    tml_geom #(
        .COORD_BITS(COORD_BITS)
    ) u_geom (
        .aclk   (aclk),
        .en_i   (en),
        .sx_i   (sx),
        .sy_i   (sy),
        .ex_i   (ex),
        .ey_i   (ey),
        .sq_o   (sq),
        .q_o    (q),
        .tri_o  (tri_g),
        .equi_o (equi_g)
    );

    // Lengths: sqrt(sq * 4^F). Area: sqrt(q * 4^F) / 4, since q is 16 * area^2.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rad[i] = AR_W'(sq[i]) << (2 * FRAC_BITS);
        end
        rad[3] = AR_W'(q) << (2 * FRAC_BITS);
    end

    for (genvar g = 0; g < 4; g++) begin : g_sqrt
        tml_isqrt #(
            .RAD_W(AR_W)
        ) u_isqrt (
            .aclk   (aclk),
            .en_i   (en),
            .rad_i  (rad[g]),
            .root_o (root[g])
        );
    end

    // Carry valid bits alongside the whole pipeline and the two flags alongside the square-root stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_dly_reg  <= {tri_dly_reg[RT-2:0], tri_g};
            equi_dly_reg <= {equi_dly_reg[RT-2:0], equi_g};
        end
    end

    assign len_sum = (RT+2)'(root[0]) + (RT+2)'(root[1]) + (RT+2)'(root[2]);

    always_comb begin
        res.is_triangle     = tri_dly_reg[RT-1];
        res.area_fixed      = AREA_W'(root[3] >> 2);
        res.perimeter_fixed = PERIM_W'(len_sum);
        res.is_equilateral  = equi_dly_reg[RT-1];
    end

    tml_obuf u_obuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (en && vld_reg[DEPTH-1]),
        .push_data_i (res),
        .full_o      (full),
        .m_valid_o   (m_valid),
        .m_ready_i   (m_ready),
        .m_data_o    (m_data)
    );

    assign m_is_triangle     = m_data.is_triangle;
    assign m_area_fixed      = m_data.area_fixed;
    assign m_perimeter_fixed = m_data.perimeter_fixed;
    assign m_is_equilateral  = m_data.is_equilateral;

endmodule
